FILE: design/text_console_character_writer_defines.svh
// ---------------------------------------------------------------------------
// Text console character writer - assertion macros
// Shared macros for the concurrent checks of the console block.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH

// check gated off while reset is held
`define TCCW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also looks at the reset itself
`define TCCW_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tccw_pkg.sv
// ---------------------------------------------------------------------------
// Text console character writer - package
// Types, codes and constants shared by the console modules.
// ---------------------------------------------------------------------------
package tccw_pkg;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CURSOR_X_W  = 7;
    localparam int CURSOR_Y_W  = 5;
    localparam int CURSOR_P_W  = 11;
    localparam int CELL_W      = 16;

    localparam logic [S_TUSER_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [S_TUSER_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [S_TUSER_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] PRINT_FIRST    = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_LAST     = 8'h7F;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [CELL_W-1:0] ZERO_CELL  = 16'h0000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  character;
        logic [ATTR_W-1:0]  attribute;
        logic [INDEX_W-1:0] cell_index;
    } item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL_COPY,
        ST_SCROLL_BLANK,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

FILE: design/text_console_character_writer.sv
// ---------------------------------------------------------------------------
// Text console character writer - top level
// Character-cell screen store with cursor, wrap, backspace, scroll, clear and read.
// ---------------------------------------------------------------------------
// After reset the screen RAM is swept to zero, during which s_axis_tready
// stays low. The front end classifies each word into a two-entry queue; the
// back end runs one operation at a time against the single-write-port screen
// RAM. A put at the end of the bottom row or a newline on the bottom row
// scrolls: the rows are copied up with one RAM write per cycle and then the
// bottom row is blanked. While a result waits in the result register, words
// are still taken into the queue until it is full, but the back end starts
// no new operation.
module text_console_character_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // character, attribute, cell_index
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // cursor_x, cursor_y, cursor_position,
                                                 // cell_word, scrolled
);

    back_status_t status;
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;
    item_t        q_in;
    item_t        q_out;

    tccw_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .status        (status),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    tccw_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .valid   (q_valid)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_out),
        .q_pop         (q_pop),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: design/tccw_ram.sv
// ---------------------------------------------------------------------------
// Text console character writer - generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tccw_front.sv
// ---------------------------------------------------------------------------
// Text console character writer - front end
// Accepts input words and sorts each into an operation for the queue.
// ---------------------------------------------------------------------------
module tccw_front
    import tccw_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // character, attribute, cell_index
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // command
    input  logic                 q_full,
    input  back_status_t         status,
    output logic                 q_push,
    output item_t                q_item
);

    logic [CHAR_W-1:0] character;
    op_t               op;

    assign character = s_axis_tdata[7:0];

    always_comb begin
        unique case (s_axis_tuser)
            CMD_PUT: begin
                if (character == CHAR_NEWLINE) begin
                    op = OP_NEWLINE;
                end else if (character == CHAR_BACKSPACE) begin
                    op = OP_BACKSPACE;
                end else if (character >= PRINT_FIRST && character <= PRINT_LAST) begin
                    op = OP_PRINT;
                end else begin
                    op = OP_NOP;
                end
            end
            CMD_CLEAR: op = OP_CLEAR;
            CMD_READ:  op = OP_READ;
            default:   op = OP_NOP;
        endcase
    end

    assign q_item.op         = op;
    assign q_item.character  = character;
    assign q_item.attribute  = s_axis_tdata[15:8];
    assign q_item.cell_index = s_axis_tdata[26:16];

    assign s_axis_tready = !q_full && !status.init_busy;
    assign q_push        = s_axis_tvalid && s_axis_tready;

endmodule

FILE: design/tccw_queue.sv
// ---------------------------------------------------------------------------
// Text console character writer - operation queue
// Short FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module tccw_queue
    import tccw_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t din,
    output logic  full,
    input  logic  pop,
    output item_t dout,
    output logic  valid
);

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = entry_reg[rd_ptr_reg];

endmodule

FILE: design/tccw_back.sv
// ---------------------------------------------------------------------------
// Text console character writer - back end
// Cursor, screen RAM sequencer (init, clear, scroll) and result register.
// ---------------------------------------------------------------------------
module tccw_back
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output back_status_t         status,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CNTW      = $clog2(CELLS + 1);
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    localparam logic [CW-1:0]   COL_LAST      = CW'(COLUMNS - 1);
    localparam logic [RW-1:0]   ROW_LAST      = RW'(ROWS - 1);
    localparam logic [AW-1:0]   POS_LAST_BASE = AW'(LAST_BASE);
    localparam logic [CNTW-1:0] CNT_CELLS     = CNTW'(CELLS);
    localparam logic [CNTW-1:0] CNT_LAST_CELL = CNTW'(CELLS - 1);
    localparam logic [CNTW-1:0] CNT_COLUMNS   = CNTW'(COLUMNS);
    localparam logic [CNTW-1:0] CNT_LAST_COPY = CNTW'(LAST_BASE - 1);
    localparam logic [AW:0]     POS_ROW_STEP  = (AW + 1)'(COLUMNS);

    state_t               state_reg, state_next;
    item_t                item_reg, item_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [CNTW-1:0]      ra_reg, ra_next;
    logic [CNTW-1:0]      wa_reg, wa_next;
    logic                 rpend_reg, rpend_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic              slot_free;
    logic              need_scroll;
    logic              in_range;
    logic [AW-1:0]     pos_dec;
    logic [AW-1:0]     pos_nl;
    logic              done;
    logic [CELL_W-1:0] res_word;
    logic              res_scrolled;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_free   = !out_valid_reg || m_axis_tready;
    assign q_pop       = (state_reg == ST_IDLE) && q_valid && slot_free;
    assign need_scroll = (row_reg == ROW_LAST) &&
                         ((item_reg.op == OP_NEWLINE) ||
                          (item_reg.op == OP_PRINT && col_reg == COL_LAST));
    assign in_range    = (32'(item_reg.cell_index) < CELLS);
    assign pos_dec     = pos_reg - AW'(1);
    assign pos_nl      = AW'({1'b0, pos_reg} - (AW + 1)'(col_reg) + POS_ROW_STEP);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_INIT: begin
                if (wa_reg == CNT_LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_pop) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (item_reg.op) inside
                    OP_PRINT, OP_NEWLINE: begin
                        state_next = need_scroll ? ST_SCROLL_COPY : ST_IDLE;
                    end
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_READ:  state_next = ST_READ_WAIT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_READ_WAIT: state_next = ST_IDLE;
            ST_SCROLL_COPY: begin
                if (rpend_reg && wa_reg == CNT_LAST_COPY) begin
                    state_next = ST_SCROLL_BLANK;
                end
            end
            ST_SCROLL_BLANK, ST_CLEAR: begin
                if (wa_reg == CNT_LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        item_next    = item_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pos_next     = pos_reg;
        ra_next      = ra_reg;
        wa_next      = wa_reg;
        rpend_next   = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = wa_reg[AW-1:0];
        mem_wdata    = ZERO_CELL;
        mem_re       = 1'b0;
        mem_raddr    = ra_reg[AW-1:0];
        done         = 1'b0;
        res_word     = ZERO_CELL;
        res_scrolled = 1'b0;

        unique case (state_reg) inside
            ST_INIT, ST_CLEAR: begin
                mem_we  = 1'b1;
                wa_next = wa_reg + CNTW'(1);
                if (wa_reg == CNT_LAST_CELL) begin
                    wa_next = '0;
                    done    = (state_reg == ST_CLEAR);
                end
            end
            ST_IDLE: begin
                if (q_pop) begin
                    item_next = q_item;
                end
            end
            ST_EXEC: begin
                unique case (item_reg.op)
                    OP_PRINT: begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg;
                        mem_wdata = {item_reg.attribute, item_reg.character};
                        pos_next  = pos_reg + AW'(1);
                        if (col_reg == COL_LAST) begin
                            col_next = '0;
                            row_next = row_reg + RW'(1);
                        end else begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                    OP_NEWLINE: begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                        pos_next = pos_nl;
                    end
                    OP_BACKSPACE: begin
                        mem_we    = 1'b1;
                        mem_wdata = BLANK_CELL;
                        if (col_reg == '0 && row_reg == '0) begin
                            mem_waddr = pos_reg;
                        end else begin
                            mem_waddr = pos_dec;
                            pos_next  = pos_dec;
                            if (col_reg == '0) begin
                                col_next = COL_LAST;
                                row_next = row_reg - RW'(1);
                            end else begin
                                col_next = col_reg - CW'(1);
                            end
                        end
                    end
                    OP_CLEAR: begin
                        col_next = '0;
                        row_next = '0;
                        pos_next = '0;
                        wa_next  = '0;
                    end
                    OP_READ: begin
                        mem_re    = in_range;
                        mem_raddr = AW'(item_reg.cell_index);
                    end
                    default: begin
                    end
                endcase
                if (need_scroll) begin
                    col_next = '0;
                    row_next = ROW_LAST;
                    pos_next = POS_LAST_BASE;
                    ra_next  = CNT_COLUMNS;
                    wa_next  = '0;
                end else if (item_reg.op != OP_CLEAR && item_reg.op != OP_READ) begin
                    done = 1'b1;
                end
            end
            ST_READ_WAIT: begin
                done     = 1'b1;
                res_word = in_range ? mem_rdata : ZERO_CELL;
            end
            ST_SCROLL_COPY: begin
                if (ra_reg < CNT_CELLS) begin
                    mem_re     = 1'b1;
                    ra_next    = ra_reg + CNTW'(1);
                    rpend_next = 1'b1;
                end
                if (rpend_reg) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    wa_next   = wa_reg + CNTW'(1);
                end
            end
            ST_SCROLL_BLANK: begin
                mem_we    = 1'b1;
                mem_wdata = BLANK_CELL;
                wa_next   = wa_reg + CNTW'(1);
                if (wa_reg == CNT_LAST_CELL) begin
                    done         = 1'b1;
                    res_scrolled = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (done) begin
            out_valid_next = 1'b1;
            out_data_next  = {res_scrolled, res_word, CURSOR_P_W'(pos_next),
                              CURSOR_Y_W'(row_next), CURSOR_X_W'(col_next)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            pos_reg       <= '0;
            wa_reg        <= '0;
            rpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            wa_reg        <= wa_next;
            rpend_reg     <= rpend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        ra_reg       <= ra_next;
        out_data_reg <= out_data_next;
    end

    assign status.init_busy = (state_reg == ST_INIT);
    assign m_axis_tvalid    = out_valid_reg;
    assign m_axis_tdata     = out_data_reg;

endmodule

FILE: design/tccw_checker.sv
// ---------------------------------------------------------------------------
// Text console character writer - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_character_writer_defines.svh"

module tccw_checker
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    `TCCW_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `TCCW_ASSERT_RST(a_init_sweep, aclk, !aresetn |=> !s_axis_tready && !m_axis_tvalid, "word taken or result shown during screen sweep")
    `TCCW_ASSERT(a_scroll_cursor, aclk, aresetn, m_axis_tvalid && m_axis_tdata[39] |-> m_axis_tdata[6:0] == 7'd0 && m_axis_tdata[11:7] == 5'(ROWS - 1) && m_axis_tdata[38:23] == 16'd0, "scroll result with bad cursor or data")
    `TCCW_ASSERT(a_cursor_pos, aclk, aresetn, m_axis_tvalid |-> COLUMNS * ROWS > 2048 || ROWS > 32 || int'(m_axis_tdata[22:12]) == int'(m_axis_tdata[11:7]) * COLUMNS + int'(m_axis_tdata[6:0]), "cursor position disagrees with row and column")

endmodule

bind text_console_character_writer tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (.*);
